### rtl/cvr_pkg.sv
// Shared types and constants for the complex vector reduce engine.
// Used by cvr_front, cvr_back and the top level.
package cvr_pkg;

  localparam logic [1:0] MODE_SUM  = 2'd0;
  localparam logic [1:0] MODE_DOT  = 2'd1;
  localparam logic [1:0] MODE_NORM = 2'd2;
  localparam logic [1:0] MODE_PROJ = 2'd3;

  localparam int unsigned AccW  = 43;
  localparam int unsigned TermW = 34;
  localparam int unsigned EnW   = 42;

  // one classified element, as queued between front and back
  typedef struct packed {
    logic signed [TermW-1:0] t_re;
    logic signed [TermW-1:0] t_im;
    logic [31:0]             t_en;
    logic [1:0]              mode;
    logic                    last;
  } entry_t;

endpackage

### rtl/cvr_front.sv
// Front end: mode register, input accept, term products and a two-entry queue.
// Depends on cvr_pkg.
module cvr_front import cvr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mode_we_i,
  input  logic [1:0]         mode_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] a_re_i,
  input  logic signed [15:0] a_im_i,
  input  logic signed [15:0] b_re_i,
  input  logic signed [15:0] b_im_i,
  input  logic               last_elem_i,
  output logic               q_valid_o,
  output entry_t             q_entry_o,
  input  logic               q_pop_i
);

  logic [1:0]  mode_q;
  entry_t      mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push;
  entry_t      ent;
  logic signed [31:0] p_rr, p_ii, p_ri, p_ir, p_aa, p_bb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DOT;
    end else if (mode_we_i) begin
      mode_q <= mode_wdata_i;
    end
  end

  assign p_rr = a_re_i * b_re_i;
  assign p_ii = a_im_i * b_im_i;
  assign p_ri = a_re_i * b_im_i;
  assign p_ir = a_im_i * b_re_i;
  assign p_aa = a_re_i * a_re_i;
  assign p_bb = a_im_i * a_im_i;

  always_comb begin
    ent      = '0;
    ent.mode = mode_q;
    ent.last = last_elem_i;
    ent.t_en = 32'($unsigned(p_aa)) + 32'($unsigned(p_bb));
    if (mode_q == MODE_SUM || mode_q == MODE_NORM) begin
      ent.t_re = TermW'(a_re_i);
      ent.t_im = TermW'(a_im_i);
    end else begin
      ent.t_re = TermW'(p_rr) + TermW'(p_ii);
      ent.t_im = TermW'(p_ri) - TermW'(p_ir);
    end
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> count_q != 2'd0) else $error("pop from empty queue");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 && !q_pop_i |=> count_q == 2'd2) else $error("full queue changed");

endmodule

### rtl/cvr_back.sv
// Back end: saturating accumulators, iterative square root and divider,
// output register. Depends on cvr_pkg.
module cvr_back import cvr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  entry_t                 q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [AccW-1:0] result_re_o,
  output logic signed [AccW-1:0] result_im_o,
  output logic                   status_o
);

  localparam int unsigned NumW = AccW + FRAC_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q;
  logic signed [AccW-1:0] acc_re_q, acc_im_q, res_re_q, res_im_q;
  logic [EnW-1:0] acc_en_q, den_q, x_q, rt_q, bit_q, rem_re_q, rem_im_q;
  logic [NumW-1:0] num_re_q, num_im_q;
  logic neg_re_q, neg_im_q, res_st_q;
  logic [CntW-1:0] cnt_q;

  logic signed [AccW:0] s_re, s_im;
  logic [AccW:0] s_en;
  logic signed [AccW-1:0] n_re, n_im;
  logic [EnW-1:0] n_en;
  logic [AccW-1:0] mag_re, mag_im;
  logic [EnW-1:0] rb;
  logic [EnW:0] sh_re, sh_im;
  logic ge_re, ge_im;
  logic load_out;

  function automatic logic signed [AccW-1:0] q_sat(logic [NumW-1:0] q, logic neg);
    logic big;
    big = (q >> 31) != '0;
    if (neg) begin
      if (big && q != (NumW'(1) << 31)) return -(AccW'(64'sd2147483648));
      return -AccW'(q);
    end
    if (big) return AccW'(64'sd2147483647);
    return AccW'(q);
  endfunction

  assign q_pop_o  = (state_q == ST_ACC) && q_valid_i;
  assign load_out = (state_q == ST_DONE) && (!out_valid_o || out_ready_i);

  always_comb begin
    s_re = (AccW+1)'(acc_re_q) + (AccW+1)'(q_entry_i.t_re);
    s_im = (AccW+1)'(acc_im_q) + (AccW+1)'(q_entry_i.t_im);
    s_en = (AccW+1)'(acc_en_q) + (AccW+1)'(q_entry_i.t_en);
    // clamp re and im to the signed accumulator range, the energy sum to its unsigned range
    if (s_re[AccW] != s_re[AccW-1]) n_re = {s_re[AccW], {(AccW-1){~s_re[AccW]}}};
    else n_re = s_re[AccW-1:0];
    if (s_im[AccW] != s_im[AccW-1]) n_im = {s_im[AccW], {(AccW-1){~s_im[AccW]}}};
    else n_im = s_im[AccW-1:0];
    if (s_en[AccW:EnW] != '0) n_en = '1;
    else n_en = s_en[EnW-1:0];
    mag_re = n_re[AccW-1] ? AccW'(-n_re) : AccW'(n_re);
    mag_im = n_im[AccW-1] ? AccW'(-n_im) : AccW'(n_im);
    rb     = rt_q + bit_q;
    sh_re  = {rem_re_q, num_re_q[NumW-1]};
    sh_im  = {rem_im_q, num_im_q[NumW-1]};
    ge_re  = sh_re >= {1'b0, den_q};
    ge_im  = sh_im >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ACC: begin
        if (q_valid_i && q_entry_i.last) begin
          x_q      <= n_en;
          rt_q     <= '0;
          bit_q    <= EnW'(1) << (EnW - 2);
          den_q    <= n_en;
          rem_re_q <= '0;
          rem_im_q <= '0;
          num_re_q <= NumW'(mag_re) << FRAC_BITS;
          num_im_q <= NumW'(mag_im) << FRAC_BITS;
          neg_re_q <= n_re[AccW-1];
          neg_im_q <= n_im[AccW-1];
          if (q_entry_i.mode == MODE_PROJ && n_en == '0) begin
            res_re_q <= '0;
            res_im_q <= '0;
            res_st_q <= 1'b1;
          end else begin
            res_re_q <= n_re;
            res_im_q <= n_im;
            res_st_q <= 1'b0;
          end
        end
      end
      ST_SQRT: begin
        if (x_q >= rb) begin
          x_q  <= x_q - rb;
          rt_q <= (rt_q >> 1) + bit_q;
        end else begin
          rt_q <= rt_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == EnW'(1)) begin
          res_re_q <= (x_q >= rb) ? AccW'((rt_q >> 1) + bit_q) : AccW'(rt_q >> 1);
          res_im_q <= '0;
        end
      end
      ST_DIV: begin
        if (cnt_q != '0) begin
          rem_re_q <= ge_re ? EnW'(sh_re - {1'b0, den_q}) : sh_re[EnW-1:0];
          rem_im_q <= ge_im ? EnW'(sh_im - {1'b0, den_q}) : sh_im[EnW-1:0];
          num_re_q <= {num_re_q[NumW-2:0], ge_re};
          num_im_q <= {num_im_q[NumW-2:0], ge_im};
        end else begin
          res_re_q <= q_sat(num_re_q, neg_re_q);
          res_im_q <= q_sat(num_im_q, neg_im_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      acc_en_q    <= '0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      result_re_o <= '0;
      result_im_o <= '0;
      status_o    <= 1'b0;
    end else begin
      // hand over once the output register is free
      if (load_out) begin
        out_valid_o <= 1'b1;
        result_re_o <= res_re_q;
        result_im_o <= res_im_q;
        status_o    <= res_st_q;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_ACC: begin
          if (q_valid_i) begin
            if (q_entry_i.last) begin
              acc_re_q <= '0;
              acc_im_q <= '0;
              acc_en_q <= '0;
              cnt_q    <= CntW'(NumW);
              case (q_entry_i.mode)
                MODE_NORM: state_q <= ST_SQRT;
                MODE_PROJ: state_q <= (n_en == '0) ? ST_DONE : ST_DIV;
                default:   state_q <= ST_DONE;
              endcase
            end else begin
              acc_re_q <= n_re;
              acc_im_q <= n_im;
              acc_en_q <= n_en;
            end
          end
        end
        ST_SQRT: begin
          if (bit_q == EnW'(1)) state_q <= ST_DONE;
        end
        ST_DIV: begin
          if (cnt_q == '0) state_q <= ST_DONE;
          else cnt_q <= cnt_q - CntW'(1);
        end
        default: begin
          if (load_out) state_q <= ST_ACC;
        end
      endcase
    end
  end

  a_pop_in_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == ST_ACC) else $error("pop outside accumulate");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> result_re_o == '0 && result_im_o == '0)
    else $error("error result not zero");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q <= CntW'(NumW)) else $error("divide count out of range");
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_entry_i.last |=> acc_en_q == '0) else $error("accumulator not cleared");

endmodule

### rtl/complex_vector_reduce_engine.sv
// Complex vector reduce engine: streams element pairs (a, b) and on the element
// flagged last returns sum(a), sum(conj(a)*b), floor isqrt(sum|a|^2) or the
// projection sum(conj(a)*b)/sum|a|^2 in Q(FRAC_BITS), saturated to 32 bits;
// status is 1 on a zero projection denominator. Elements are accumulated one
// per cycle while the back end is not busy. At a vector end the back end
// goes straight to the output (sum, dot, zero denominator), computes 21 root
// digits, one per cycle (norm), or 43 + FRAC_BITS quotient bits, one per cycle
// for both parts, then saturates (projection); the result is then loaded into
// the output register, which also waits while a result is held there; a
// two-entry queue keeps accepting input meanwhile until it fills. Mode must be
// written by the user only while idle; the block itself does not enforce this.
module complex_vector_reduce_engine import cvr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   mode_we_i,
  input  logic [1:0]             mode_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [15:0]     a_re_i,
  input  logic signed [15:0]     a_im_i,
  input  logic signed [15:0]     b_re_i,
  input  logic signed [15:0]     b_im_i,
  input  logic                   last_elem_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [AccW-1:0] result_re_o,
  output logic signed [AccW-1:0] result_im_o,
  output logic                   status_o
);

  logic   q_valid, q_pop;
  entry_t q_entry;

  cvr_front u_front (
    .clk_i, .rst_ni, .mode_we_i, .mode_wdata_i, .in_valid_i, .in_ready_o,
    .a_re_i, .a_im_i, .b_re_i, .b_im_i, .last_elem_i,
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  cvr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_ready_i, .result_re_o, .result_im_o, .status_o
  );

endmodule
